// File: hw/rtl/tcsb_pkg.sv
package tcsb_pkg;

	// Defaults for the top level parameters.
	localparam int ROW_CAPACITY_DEF = 256;
	localparam int LINE_WIDTH_DEF   = 80;

	// Fixed field widths.
	localparam int COL_W     = 7;
	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 24;
	localparam int CELL_DW   = CHAR_W + COLOR_W;
	localparam int VROWS_W   = 9;
	localparam int CFG_AW    = 4;
	localparam int CFG_DW    = 32;

	// Item modes.
	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// Special characters.
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	// Register indexes (word address bits of paddr).
	localparam logic [1:0] REG_VISIBLE_ROWS = 2'd0;
	localparam logic [1:0] REG_VISIBLE_COLS = 2'd1;
	localparam logic [1:0] REG_BACKGROUND   = 2'd2;

	// Register reset values.
	localparam logic [VROWS_W-1:0] VISIBLE_ROWS_RST = 9'd48;
	localparam logic [COL_W-1:0]   VISIBLE_COLS_RST = 7'd80;
	localparam logic [COLOR_W-1:0] BACKGROUND_RST   = 24'h121820;

	// Configuration handed from the register block to the datapath.
	typedef struct packed {
		logic [VROWS_W-1:0] visible_rows;
		logic [COL_W-1:0]   visible_cols;
		logic [COLOR_W-1:0] background_color;
	} cfg_t;

endpackage

// File: hw/rtl/tcsb_ram.sv
module tcsb_ram import tcsb_pkg::*; #(
	parameter int WIDTH = CELL_DW,
	parameter int DEPTH = ROW_CAPACITY_DEF * LINE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port; the read port returns the old data on a collision.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/tcsb_cfg.sv
module tcsb_cfg import tcsb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.visible_rows     <= VISIBLE_ROWS_RST;
			cfg_q.visible_cols     <= VISIBLE_COLS_RST;
			cfg_q.background_color <= BACKGROUND_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_VISIBLE_ROWS: cfg_q.visible_rows     <= pwdata[VROWS_W-1:0];
				REG_VISIBLE_COLS: cfg_q.visible_cols     <= pwdata[COL_W-1:0];
				REG_BACKGROUND:   cfg_q.background_color <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data, zero for unused addresses.
	always_comb begin
		case (paddr[3:2])
			REG_VISIBLE_ROWS: prdata = CFG_DW'(cfg_q.visible_rows);
			REG_VISIBLE_COLS: prdata = CFG_DW'(cfg_q.visible_cols);
			REG_BACKGROUND:   prdata = CFG_DW'(cfg_q.background_color);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/text_console_scrollback_buffer.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_stall | mode, char_code, char_color, read_row, read_col
// rsp     | out       | rsp_valid / rsp_stall | cell_char, cell_color, cursor_row, cursor_col,
//         |           |                       | view_top
// cfg     | in        | APB psel/penable      | paddr, pwdata, prdata, pready
//
// One item is taken per cycle while no result is stalled; it passes stages 1, 2 and 3, then the result register.
// The cell memory and the row length memory are each read and written at most once per cycle.
// Reset clears the cursor and ring state; the memories need no clearing pass.
// The whole pipeline holds while a result is stalled, and req_stall follows it.
module text_console_scrollback_buffer import tcsb_pkg::*; #(
	parameter int ROW_CAPACITY = ROW_CAPACITY_DEF,
	parameter int LINE_WIDTH   = LINE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [CFG_AW-1:0]  paddr,
	input  logic [CFG_DW-1:0]  pwdata,
	output logic [CFG_DW-1:0]  prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         mode,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [COLOR_W-1:0] char_color,
	input  logic [7:0]         read_row,
	input  logic [COL_W-1:0]   read_col,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [CHAR_W-1:0]  cell_char,
	output logic [COLOR_W-1:0] cell_color,
	output logic [7:0]         cursor_row,
	output logic [COL_W-1:0]   cursor_col,
	output logic [7:0]         view_top
);

	localparam int ROW_W     = $clog2(ROW_CAPACITY);
	localparam int LOG_W     = ((ROW_W > 8) ? ROW_W : 8) + 1;
	localparam int CELLS     = ROW_CAPACITY * LINE_WIDTH;
	localparam int CELL_AW   = $clog2(CELLS);
	localparam int BASE_LAST = (ROW_CAPACITY - 1) * LINE_WIDTH;

	localparam logic [ROW_W-1:0]   ROW_LAST = ROW_W'(ROW_CAPACITY - 1);
	localparam logic [CELL_AW-1:0] BASE_END = CELL_AW'(BASE_LAST);
	localparam logic [COL_W-1:0]   LW_COL   = COL_W'(LINE_WIDTH);

	// One item in flight. The row field holds the logical row in stage 1
	// and the physical row from stage 2 on.
	typedef struct packed {
		logic               rd;
		logic               blank;
		logic               is_cur;
		logic [ROW_W-1:0]   row;
		logic [ROW_W-1:0]   base_row;
		logic [COL_W-1:0]   col;
		logic [COL_W-1:0]   wcol;
		logic               cell_we;
		logic [CELL_AW-1:0] cell_waddr;
		logic [CELL_DW-1:0] cell_wdata;
		logic               len_we;
		logic [ROW_W-1:0]   len_waddr;
		logic [COL_W-1:0]   len_wdata;
		logic [7:0]         cur_row;
		logic [COL_W-1:0]   cur_col;
		logic [7:0]         top;
	} item_t;

	cfg_t cfg;

	// Cursor and ring state.
	logic [ROW_W-1:0]   line_count_q, ring_base_q, cur_phys_q, view_row_q;
	logic [CELL_AW-1:0] cur_base_q;
	logic [COL_W-1:0]   write_col_q, cur_len_q;

	// Next state for the item at the input.
	logic [ROW_W-1:0]   lc_n, rb_n, phys_n, view_n;
	logic [CELL_AW-1:0] base_n;
	logic [COL_W-1:0]   wc_n, len_n, put_col;
	logic               new_line, put_cell, clear;
	logic [VROWS_W-1:0] rows;
	logic [LOG_W-1:0]   lc_plus, lc_ext, view_ext, logical;
	item_t              item_in;

	// Pipeline.
	logic               advance, accept;
	logic               v_s1, v_s2, v_s3;
	item_t              item_s1, item_s2, item_s3;
	item_t              item_s1_map;
	logic [ROW_W:0]     phys_sum;
	logic [ROW_W-1:0]   phys_row;
	logic [CELL_AW-1:0] rd_addr;
	logic               rd_en;
	logic [CELL_DW-1:0] cell_rdata;
	logic [COL_W-1:0]   len_rdata;

	// Result stage.
	logic [COL_W-1:0]   row_len;
	logic               blank_s3;
	logic [CHAR_W-1:0]  char_s3;
	logic [COLOR_W-1:0] color_s3;
	logic               rsp_valid_q;
	logic [CHAR_W-1:0]  cell_char_q;
	logic [COLOR_W-1:0] cell_color_q;
	logic [7:0]         cursor_row_q, view_top_q;
	logic [COL_W-1:0]   cursor_col_q;

	tcsb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The pipeline moves as a whole whenever the result register is empty or its result is taken.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign accept    = req_valid && advance;
	assign req_stall = !advance;

	// Put and clear: next cursor state and the memory writes they cause.
	always_comb begin
		lc_n     = line_count_q;
		rb_n     = ring_base_q;
		phys_n   = cur_phys_q;
		base_n   = cur_base_q;
		wc_n     = write_col_q;
		len_n    = cur_len_q;
		view_n   = view_row_q;
		new_line = 1'b0;
		put_cell = 1'b0;
		clear    = 1'b0;
		put_col  = write_col_q;
		rows     = (cfg.visible_rows == '0) ? VROWS_W'(1) : cfg.visible_rows;
		case (mode)
			MODE_PUT: begin
				if (char_code == CH_LF) begin
					new_line = 1'b1;
				end else if (char_code == CH_CR) begin
					wc_n = '0;
				end else begin
					put_cell = 1'b1;
					if (write_col_q >= LW_COL) begin
						new_line = 1'b1;
						put_col  = '0;
					end
				end
			end
			MODE_CLEAR: clear = 1'b1;
			default: ;
		endcase
		if (new_line) begin
			if (line_count_q < ROW_LAST) begin
				lc_n = line_count_q + ROW_W'(1);
			end else begin
				rb_n = (ring_base_q == ROW_LAST) ? '0 : ring_base_q + ROW_W'(1);
			end
			phys_n = (cur_phys_q == ROW_LAST) ? '0 : cur_phys_q + ROW_W'(1);
			base_n = (cur_base_q == BASE_END) ? '0 : cur_base_q + CELL_AW'(LINE_WIDTH);
			wc_n   = '0;
			len_n  = '0;
		end
		// The view keeps the current line at its bottom.
		lc_plus = LOG_W'(lc_n) + LOG_W'(1);
		if (new_line) begin
			view_n = (lc_plus > LOG_W'(rows)) ? ROW_W'(lc_plus - LOG_W'(rows)) : '0;
		end
		if (put_cell) begin
			wc_n = put_col + COL_W'(1);
			if (len_n < wc_n) begin
				len_n = wc_n;
			end
		end
		if (clear) begin
			lc_n   = '0;
			rb_n   = '0;
			phys_n = '0;
			base_n = '0;
			wc_n   = '0;
			len_n  = '0;
			view_n = '0;
		end
	end

	// Read: range checks and the logical row, against the state before the item.
	assign logical = LOG_W'(view_row_q) + LOG_W'(read_row);
	assign lc_ext  = LOG_W'(lc_n);
	assign view_ext = LOG_W'(view_n);

	always_comb begin
		item_in            = '0;
		item_in.rd         = (mode == MODE_READ);
		item_in.blank      = ({1'b0, read_row} >= cfg.visible_rows) ||
		                     (read_col >= cfg.visible_cols) || (read_col >= LW_COL) ||
		                     (logical > LOG_W'(line_count_q));
		item_in.is_cur     = (logical == LOG_W'(line_count_q));
		item_in.row        = logical[ROW_W-1:0];
		item_in.base_row   = ring_base_q;
		item_in.col        = read_col;
		item_in.wcol       = write_col_q;
		item_in.cell_we    = put_cell;
		item_in.cell_waddr = base_n + CELL_AW'(put_col);
		item_in.cell_wdata = {char_code, char_color};
		item_in.len_we     = new_line;
		item_in.len_waddr  = cur_phys_q;
		item_in.len_wdata  = cur_len_q;
		item_in.cur_row    = lc_ext[7:0];
		item_in.cur_col    = wc_n;
		item_in.top        = view_ext[7:0];
	end

	// Cursor state is committed at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			ring_base_q  <= '0;
			cur_phys_q   <= '0;
			cur_base_q   <= '0;
			write_col_q  <= '0;
			cur_len_q    <= '0;
			view_row_q   <= '0;
		end else if (accept) begin
			line_count_q <= lc_n;
			ring_base_q  <= rb_n;
			cur_phys_q   <= phys_n;
			cur_base_q   <= base_n;
			write_col_q  <= wc_n;
			cur_len_q    <= len_n;
			view_row_q   <= view_n;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= req_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			rsp_valid_q <= v_s3;
		end
	end

	// Stage 1 to 2: map the logical row onto the ring.
	assign phys_sum = (ROW_W + 1)'(item_s1.base_row) + (ROW_W + 1)'(item_s1.row);
	assign phys_row = (phys_sum >= (ROW_W + 1)'(ROW_CAPACITY)) ?
	                  ROW_W'(phys_sum - (ROW_W + 1)'(ROW_CAPACITY)) : ROW_W'(phys_sum);

	always_comb begin
		item_s1_map     = item_s1;
		item_s1_map.row = phys_row;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item_in;
			item_s2 <= item_s1_map;
			item_s3 <= item_s2;
		end
	end

	// Stage 2: memory access. Writes of puts happen here too, so that every
	// read sees exactly the puts accepted before it.
	assign rd_addr = CELL_AW'(item_s2.row) * CELL_AW'(LINE_WIDTH) + CELL_AW'(item_s2.col);
	assign rd_en   = advance && v_s2 && item_s2.rd && !item_s2.blank;

	tcsb_ram #(
		.WIDTH (CELL_DW),
		.DEPTH (CELLS)
	) u_cell_mem (
		.clk   (clk),
		.we    (advance && v_s2 && item_s2.cell_we),
		.waddr (item_s2.cell_waddr),
		.wdata (item_s2.cell_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (cell_rdata)
	);

	tcsb_ram #(
		.WIDTH (COL_W),
		.DEPTH (ROW_CAPACITY)
	) u_len_mem (
		.clk   (clk),
		.we    (advance && v_s2 && item_s2.len_we),
		.waddr (item_s2.len_waddr),
		.wdata (item_s2.len_wdata),
		.re    (rd_en),
		.raddr (item_s2.row),
		.rdata (len_rdata)
	);

	// Stage 3: blank cells and spaces take the background color; items other than reads give zero char and color.
	always_comb begin
		row_len  = item_s3.is_cur ? item_s3.wcol : len_rdata;
		blank_s3 = item_s3.blank || (item_s3.col >= row_len);
		char_s3  = blank_s3 ? CH_SPACE : cell_rdata[CELL_DW-1:COLOR_W];
		color_s3 = (blank_s3 || (char_s3 == CH_SPACE)) ? cfg.background_color :
		           cell_rdata[COLOR_W-1:0];
		if (!item_s3.rd) begin
			char_s3  = '0;
			color_s3 = '0;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance && v_s3) begin
			cell_char_q  <= char_s3;
			cell_color_q <= color_s3;
			cursor_row_q <= item_s3.cur_row;
			cursor_col_q <= item_s3.cur_col;
			view_top_q   <= item_s3.top;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign cell_char  = cell_char_q;
	assign cell_color = cell_color_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;
	assign view_top   = view_top_q;

endmodule

// File: test/tb_text_console_scrollback_buffer.sv
module tb_text_console_scrollback_buffer;
	import tcsb_pkg::*;

	localparam int ROWS = ROW_CAPACITY_DEF;
	localparam int LINE_W = LINE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 200;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic [CHAR_W-1:0]  code;
		logic [COLOR_W-1:0] color;
		logic [7:0]         row;
		logic [COL_W-1:0]   col;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  ch;
		logic [COLOR_W-1:0] color;
		logic [7:0]         row;
		logic [COL_W-1:0]   col;
		logic [7:0]         top;
	} reply_t;

	typedef struct packed {
		item_t  it;
		logic   typed;
		reply_t want;
	} opening_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [CFG_AW-1:0]  paddr = '0;
	logic [CFG_DW-1:0]  pwdata = '0;
	logic [CFG_DW-1:0]  prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         mode = MODE_PUT;
	logic [CHAR_W-1:0]  char_code = '0;
	logic [COLOR_W-1:0] char_color = '0;
	logic [7:0]         read_row = '0;
	logic [COL_W-1:0]   read_col = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [CHAR_W-1:0]  cell_char;
	logic [COLOR_W-1:0] cell_color;
	logic [7:0]         cursor_row;
	logic [COL_W-1:0]   cursor_col;
	logic [7:0]         view_top;

	text_console_scrollback_buffer dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall),
		.mode(mode), .char_code(char_code), .char_color(char_color),
		.read_row(read_row), .read_col(read_col),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.cell_char(cell_char), .cell_color(cell_color),
		.cursor_row(cursor_row), .cursor_col(cursor_col), .view_top(view_top)
	);

	always #5 clk = ~clk;

	// Mirror of the console: cell memories, ring and cursor, and the registers.
	logic [CHAR_W-1:0]  glyph_mem [0:ROWS*LINE_W-1];
	logic [COLOR_W-1:0] tint_mem [0:ROWS*LINE_W-1];
	int unsigned        line_len [0:ROWS-1];
	int unsigned        base_row, cur_line, cur_col, top_line;
	int unsigned        cfg_rows, cfg_cols;
	logic [COLOR_W-1:0] cfg_bg;

	reply_t      replies_due [$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          burst_left = 1;
	int          stall_left = 0;
	opening_row_t opening_rows [22];

	function automatic void wipe_console();
		foreach (line_len[i]) line_len[i] = 0;
		base_row = 0;
		cur_line = 0;
		cur_col = 0;
		top_line = 0;
	endfunction

	// A new line scrolls the oldest row out once the ring is full.
	function automatic void start_line();
		int unsigned shown;
		if (cur_line < ROWS - 1) cur_line++;
		else base_row = (base_row + 1) % ROWS;
		line_len[(base_row + cur_line) % ROWS] = 0;
		cur_col = 0;
		shown = (cfg_rows == 0) ? 1 : cfg_rows;
		top_line = (cur_line + 1 > shown) ? cur_line + 1 - shown : 0;
	endfunction

	function automatic reply_t console_reply(item_t it);
		reply_t r;
		int unsigned p, lg, len;
		r = '0;
		case (it.mode)
			MODE_PUT: begin
				if (it.code == CH_LF) begin
					start_line();
				end else if (it.code == CH_CR) begin
					cur_col = 0;
				end else begin
					if (cur_col >= LINE_W) start_line();
					p = (base_row + cur_line) % ROWS;
					glyph_mem[p * LINE_W + cur_col] = it.code;
					tint_mem[p * LINE_W + cur_col] = it.color;
					cur_col++;
					if (line_len[p] < cur_col) line_len[p] = cur_col;
				end
			end
			MODE_READ: begin
				// Anything outside the window or past the written length is blank.
				r.ch = CH_SPACE;
				r.color = cfg_bg;
				if (it.row < cfg_rows && it.col < cfg_cols && it.col < LINE_W) begin
					lg = top_line + it.row;
					if (lg <= cur_line) begin
						p = (base_row + lg) % ROWS;
						len = (lg == cur_line) ? cur_col : line_len[p];
						if (it.col < len) begin
							r.ch = glyph_mem[p * LINE_W + it.col];
							if (r.ch != CH_SPACE) r.color = tint_mem[p * LINE_W + it.col];
						end
					end
				end
			end
			MODE_CLEAR: begin
				wipe_console();
			end
			default: ;
		endcase
		r.row = 8'(cur_line);
		r.col = 7'(cur_col);
		r.top = 8'(top_line);
		return r;
	endfunction

	// Register write: setup cycle, then access cycle; bits above the field are noise.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] word;
		word = $urandom;
		case (idx)
			REG_VISIBLE_ROWS: begin
				word[VROWS_W-1:0] = value[VROWS_W-1:0];
				cfg_rows = value[VROWS_W-1:0];
			end
			REG_VISIBLE_COLS: begin
				word[COL_W-1:0] = value[COL_W-1:0];
				cfg_cols = value[COL_W-1:0];
			end
			REG_BACKGROUND: begin
				word[COLOR_W-1:0] = value[COLOR_W-1:0];
				cfg_bg = value[COLOR_W-1:0];
			end
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Present one item, hold it until taken, then pace the next burst.
	task automatic offer(input item_t it, input logic typed, input reply_t want);
		reply_t predicted;
		@(negedge clk);
		req_valid <= 1'b1;
		mode <= it.mode;
		char_code <= it.code;
		char_color <= it.color;
		read_row <= it.row;
		read_col <= it.col;
		do @(posedge clk); while (req_stall);
		predicted = console_reply(it);
		replies_due.push_back(typed ? want : predicted);
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
	endtask

	// Stop sending and wait until every pending result has come back.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	// Receiver stall pattern: short stalls, short runs, and long free stretches.
	always @(negedge clk) begin
		int pick;
		if (stall_left <= 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				rsp_stall <= 1'b0;
				stall_left = $urandom_range(40, 120);
			end else if (pick < 6) begin
				rsp_stall <= 1'b1;
				stall_left = $urandom_range(1, 6);
			end else begin
				rsp_stall <= 1'b0;
				stall_left = $urandom_range(1, 10);
			end
		end else begin
			stall_left--;
		end
	end

	// Compare each accepted result with the oldest pending one.
	always @(posedge clk) begin
		reply_t seen, want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			seen = '{cell_char, cell_color, cursor_row, cursor_col, view_top};
			if (replies_due.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result: ch=%h color=%h row=%0d col=%0d top=%0d",
						seen.ch, seen.color, seen.row, seen.col, seen.top);
				fail_count++;
			end else begin
				want = replies_due.pop_front();
				if (seen.ch !== want.ch || seen.color !== want.color
						|| seen.row !== want.row || seen.col !== want.col
						|| seen.top !== want.top) begin
					if (fail_count < 10)
						$display("mismatch: want ch=%h color=%h row=%0d col=%0d top=%0d, got ch=%h color=%h row=%0d col=%0d top=%0d",
							want.ch, want.color, want.row, want.col, want.top,
							seen.ch, seen.color, seen.row, seen.col, seen.top);
					fail_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		item_t       it;
		int          roll, lf_pct, cr_pct, win_rows, win_cols;
		logic        clears_ok;
		logic [31:0] set_rows, set_cols, set_bg;

		wipe_console();
		cfg_rows = VISIBLE_ROWS_RST;
		cfg_cols = VISIBLE_COLS_RST;
		cfg_bg = BACKGROUND_RST;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Start from the reset settings, written out explicitly.
		write_reg(REG_VISIBLE_ROWS, VISIBLE_ROWS_RST);
		write_reg(REG_VISIBLE_COLS, VISIBLE_COLS_RST);
		write_reg(REG_BACKGROUND, BACKGROUND_RST);

		// Directed items: blanks, extremes, carriage return, line feed, clear.
		opening_rows = '{
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd0}, 1'b1,
				'{CH_SPACE, BACKGROUND_RST, 8'd0, 7'd0, 8'd0}},
			'{'{MODE_UNUSED, 8'hFF, 24'hFFFFFF, 8'hFF, 7'h7F}, 1'b1,
				'{8'h00, 24'h000000, 8'd0, 7'd0, 8'd0}},
			'{'{MODE_PUT, 8'h41, 24'hFFFFFF, 8'hFF, 7'h7F}, 1'b1,
				'{8'h00, 24'h000000, 8'd0, 7'd1, 8'd0}},
			'{'{MODE_PUT, CH_SPACE, 24'h123456, 8'd0, 7'd0}, 1'b1,
				'{8'h00, 24'h000000, 8'd0, 7'd2, 8'd0}},
			'{'{MODE_PUT, 8'hFF, 24'h000000, 8'd0, 7'd0}, 1'b1,
				'{8'h00, 24'h000000, 8'd0, 7'd3, 8'd0}},
			'{'{MODE_PUT, 8'h00, 24'hABCDEF, 8'd0, 7'd0}, 1'b1,
				'{8'h00, 24'h000000, 8'd0, 7'd4, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd0}, 1'b1,
				'{8'h41, 24'hFFFFFF, 8'd0, 7'd4, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd1}, 1'b1,
				'{CH_SPACE, BACKGROUND_RST, 8'd0, 7'd4, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd3}, 1'b1,
				'{8'h00, 24'hABCDEF, 8'd0, 7'd4, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd4}, 1'b1,
				'{CH_SPACE, BACKGROUND_RST, 8'd0, 7'd4, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'h7F}, 1'b1,
				'{CH_SPACE, BACKGROUND_RST, 8'd0, 7'd4, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'hFF, 7'd0}, 1'b1,
				'{CH_SPACE, BACKGROUND_RST, 8'd0, 7'd4, 8'd0}},
			'{'{MODE_PUT, CH_CR, 24'h000000, 8'd0, 7'd0}, 1'b1,
				'{8'h00, 24'h000000, 8'd0, 7'd0, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd3}, 1'b1,
				'{CH_SPACE, BACKGROUND_RST, 8'd0, 7'd0, 8'd0}},
			'{'{MODE_PUT, 8'h42, 24'h00FF00, 8'd0, 7'd0}, 1'b1,
				'{8'h00, 24'h000000, 8'd0, 7'd1, 8'd0}},
			'{'{MODE_PUT, CH_LF, 24'h000000, 8'd0, 7'd0}, 1'b1,
				'{8'h00, 24'h000000, 8'd1, 7'd0, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd2}, 1'b1,
				'{8'hFF, 24'h000000, 8'd1, 7'd0, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd0}, 1'b1,
				'{8'h42, 24'h00FF00, 8'd1, 7'd0, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd1}, 1'b0, '0},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd2, 7'd0}, 1'b1,
				'{CH_SPACE, BACKGROUND_RST, 8'd1, 7'd0, 8'd0}},
			'{'{MODE_CLEAR, 8'hFF, 24'hFFFFFF, 8'hFF, 7'h7F}, 1'b1,
				'{8'h00, 24'h000000, 8'd0, 7'd0, 8'd0}},
			'{'{MODE_READ, 8'h00, 24'h000000, 8'd0, 7'd0}, 1'b1,
				'{CH_SPACE, BACKGROUND_RST, 8'd0, 7'd0, 8'd0}}
		};
		foreach (opening_rows[i])
			offer(opening_rows[i].it, opening_rows[i].typed, opening_rows[i].want);

		// Random phases, each under its own window and colour settings.
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			repeat (6) @(posedge clk);
			cr_pct = 3;
			clears_ok = 1'b0;
			case (ph)
				0: begin
					// Long lines only, so the wrap at full width is reached.
					set_rows = 256; set_cols = 80; set_bg = 24'hFFFFFF;
					lf_pct = 0; cr_pct = 0;
				end
				1: begin
					set_rows = 1; set_cols = 1; set_bg = 24'h000000; lf_pct = 90;
				end
				2: begin
					set_rows = 0; set_cols = 127; set_bg = $urandom; lf_pct = 70;
				end
				3: begin
					// By now the ring fills and starts to scroll.
					set_rows = VISIBLE_ROWS_RST; set_cols = VISIBLE_COLS_RST;
					set_bg = BACKGROUND_RST; lf_pct = 60;
				end
				4: begin
					set_rows = $urandom_range(1, 256); set_cols = $urandom_range(1, 127);
					set_bg = $urandom; lf_pct = 30; clears_ok = 1'b1;
				end
				default: begin
					set_rows = 511; set_cols = 0; set_bg = $urandom;
					lf_pct = 40; clears_ok = 1'b1;
				end
			endcase
			write_reg(REG_VISIBLE_ROWS, set_rows);
			write_reg(REG_VISIBLE_COLS, set_cols);
			write_reg(REG_BACKGROUND, set_bg);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				it.code = 8'($urandom);
				it.color = 24'($urandom);
				it.row = 8'($urandom);
				it.col = 7'($urandom);
				roll = $urandom_range(0, 99);
				if (roll < 65) begin
					it.mode = MODE_PUT;
					roll = $urandom_range(0, 99);
					if (roll < lf_pct) it.code = CH_LF;
					else if (roll < lf_pct + cr_pct) it.code = CH_CR;
					else if (roll < lf_pct + cr_pct + 8) it.code = CH_SPACE;
				end else if (roll < 97) begin
					// Reads mostly land inside the window, often on the write line.
					it.mode = MODE_READ;
					win_rows = (cfg_rows == 0) ? 1 : ((cfg_rows > 256) ? 256 : cfg_rows);
					win_cols = (cfg_cols > LINE_W) ? LINE_W : cfg_cols;
					roll = $urandom_range(0, 99);
					if (roll < 40) it.row = 8'(cur_line - top_line);
					else if (roll < 85) it.row = 8'($urandom_range(0, win_rows - 1));
					roll = $urandom_range(0, 99);
					if (roll < 85 && win_cols > 0) it.col = 7'($urandom_range(0, win_cols - 1));
				end else if (roll < 99 || !clears_ok) begin
					it.mode = MODE_UNUSED;
				end else begin
					it.mode = MODE_CLEAR;
				end
				offer(it, 1'b0, '0);
				// Now and then let the pipeline run completely dry.
				if ($urandom_range(0, 99) == 0) drain();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && replies_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/tcsb_pkg.sv
hw/rtl/tcsb_ram.sv
hw/rtl/tcsb_cfg.sv
hw/rtl/text_console_scrollback_buffer.sv
test/tb_text_console_scrollback_buffer.sv
